FILE: rtl/opwfs_pkg.sv
// Package with shared types and constants for the pulse-width OOK frame sender.
package opwfs_pkg;

  localparam int FRAME_FIELD_W   = 25;
  localparam int CODE_W          = 8;
  localparam int REPS_W          = 8;
  localparam int FRAME_BITS_DEF  = 25;
  localparam int UNIT_SCALE_DEF  = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int LONG_UNITS      = 3;
  localparam int GAP_UNITS       = 30;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [FRAME_FIELD_W-1:0] frame_bits;
    logic [CODE_W-1:0]        unit_code;
    logic [REPS_W-1:0]        repeat_count;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic started;
  } result_t;

endpackage

FILE: rtl/opwfs_front.sv
// Front stage: registers each input transfer and classifies it into a command.
module opwfs_front
  import opwfs_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int UNIT_SCALE = UNIT_SCALE_DEF,
  parameter int UNIT_W     = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  cmd_valid,
  input  logic                  cmd_full,
  output logic                  cmd_load,
  output logic                  cmd_start,
  output logic [FRAME_BITS-1:0] cmd_bits,
  output logic [UNIT_W-1:0]     cmd_unit,
  output logic [REPS_W-1:0]     cmd_reps
);

  logic advance;

  assign advance    = !cmd_valid || !cmd_full;
  assign item_stall = cmd_valid && cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance) begin
      cmd_valid <= item_valid;
    end
    if (advance && item_valid) begin
      cmd_load  <= (item.action == ACT_LOAD);
      cmd_start <= (item.unit_code != '0) && (item.repeat_count != '0);
      cmd_bits  <= FRAME_BITS'(item.frame_bits);
      cmd_unit  <= UNIT_W'(item.unit_code) * UNIT_W'(UNIT_SCALE);
      cmd_reps  <= item.repeat_count;
    end
  end

endmodule

FILE: rtl/opwfs_queue.sv
// Short first-in first-out queue of commands between the front and back stages.
module opwfs_queue
  import opwfs_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/opwfs_back.sv
// Back stage: waveform sequencer that executes commands and holds the result register.
module opwfs_back
  import opwfs_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int UNIT_W     = 12,
  parameter int TIME_W     = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_take,
  input  logic                  cmd_load,
  input  logic                  cmd_start,
  input  logic [FRAME_BITS-1:0] cmd_bits,
  input  logic [UNIT_W-1:0]     cmd_unit,
  input  logic [REPS_W-1:0]     cmd_reps,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  localparam int IDX_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_GAP
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [FRAME_BITS-1:0] last_frame;
  logic [FRAME_BITS-1:0] last_frame_next;
  logic [UNIT_W-1:0] unit_us;
  logic [UNIT_W-1:0] unit_us_next;
  logic [REPS_W-1:0] repeats_left;
  logic [REPS_W-1:0] repeats_left_next;
  logic [IDX_W-1:0]  bit_index;
  logic [IDX_W-1:0]  bit_index_next;
  logic [TIME_W-1:0] time_left;
  logic [TIME_W-1:0] time_left_next;
  logic [TIME_W-1:0] time_dec;
  logic [REPS_W-1:0] reps_dec;
  logic [TIME_W-1:0] unit_t;
  logic [TIME_W-1:0] unit_long;
  logic [TIME_W-1:0] unit_gap;
  logic [TIME_W-1:0] cmd_unit_t;
  logic [IDX_W-1:0]  idx_inc;
  logic              started_next;

  assign cmd_take   = cmd_valid && (!result_valid || !result_stall);
  assign unit_t     = TIME_W'(unit_us);
  assign unit_long  = unit_t * TIME_W'(LONG_UNITS);
  assign unit_gap   = unit_t * TIME_W'(GAP_UNITS);
  assign cmd_unit_t = TIME_W'(cmd_unit);
  assign idx_inc    = bit_index + 1'b1;
  assign time_dec   = (time_left != '0) ? time_left - 1'b1 : '0;
  assign reps_dec   = (repeats_left != '0) ? repeats_left - 1'b1 : '0;

  always_comb begin
    phase_next        = phase;
    last_frame_next   = last_frame;
    unit_us_next      = unit_us;
    repeats_left_next = repeats_left;
    bit_index_next    = bit_index;
    time_left_next    = time_left;
    started_next      = 1'b0;
    if (cmd_load) begin
      if (phase == PH_IDLE && cmd_bits != last_frame) begin
        last_frame_next = cmd_bits;
        if (cmd_start) begin
          unit_us_next      = cmd_unit;
          repeats_left_next = cmd_reps;
          bit_index_next    = '0;
          phase_next        = PH_HIGH;
          time_left_next    = cmd_bits[0] ? cmd_unit_t * TIME_W'(LONG_UNITS) : cmd_unit_t;
          started_next      = 1'b1;
        end
      end
    end else if (phase != PH_IDLE) begin
      time_left_next = time_dec;
      if (time_dec == '0) begin
        case (phase)
          PH_HIGH: begin
            phase_next     = PH_LOW;
            time_left_next = last_frame[bit_index] ? unit_t : unit_long;
          end
          PH_LOW: begin
            if (bit_index == IDX_W'(FRAME_BITS - 1)) begin
              phase_next     = PH_GAP;
              time_left_next = unit_gap;
            end else begin
              bit_index_next = idx_inc;
              phase_next     = PH_HIGH;
              time_left_next = last_frame[idx_inc] ? unit_long : unit_t;
            end
          end
          PH_GAP: begin
            repeats_left_next = reps_dec;
            bit_index_next    = '0;
            if (reps_dec != '0) begin
              phase_next     = PH_HIGH;
              time_left_next = last_frame[0] ? unit_long : unit_t;
            end else begin
              phase_next     = PH_IDLE;
              time_left_next = '0;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      last_frame   <= '0;
      unit_us      <= '0;
      repeats_left <= '0;
      bit_index    <= '0;
      time_left    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        phase        <= phase_next;
        last_frame   <= last_frame_next;
        unit_us      <= unit_us_next;
        repeats_left <= repeats_left_next;
        bit_index    <= bit_index_next;
        time_left    <= time_left_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (cmd_take) begin
      result.line_level <= (phase_next == PH_HIGH);
      result.busy_res   <= (phase_next != PH_IDLE);
      result.started    <= started_next;
    end
  end

endmodule

FILE: rtl/ook_pulse_width_frame_sender.sv
// Top level of the pulse-width on-off keying frame sender.
// Accepts one item per clock cycle unless item_stall is high, and delivers one
// result per item. Tick and load items pass through a front register, a
// two-entry command queue and the waveform sequencer, which updates its state
// and its result register for each command it takes from the queue. The result
// register may hold a finished result while new items are still taken, until
// the queue fills.
module ook_pulse_width_frame_sender
  import opwfs_pkg::*;
#(
  parameter int FRAME_BITS  = FRAME_BITS_DEF,
  parameter int UNIT_SCALE  = UNIT_SCALE_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int UNIT_W = $clog2(((2 ** CODE_W) - 1) * UNIT_SCALE + 1);
  localparam int TIME_W = $clog2(((2 ** CODE_W) - 1) * UNIT_SCALE * GAP_UNITS + 1);
  localparam int CMD_W  = 2 + FRAME_BITS + UNIT_W + REPS_W;

  logic                  f_valid;
  logic                  q_full;
  logic                  f_load;
  logic                  f_start;
  logic [FRAME_BITS-1:0] f_bits;
  logic [UNIT_W-1:0]     f_unit;
  logic [REPS_W-1:0]     f_reps;
  logic                  q_valid;
  logic [CMD_W-1:0]      q_data;
  logic                  q_pop;
  logic                  b_load;
  logic                  b_start;
  logic [FRAME_BITS-1:0] b_bits;
  logic [UNIT_W-1:0]     b_unit;
  logic [REPS_W-1:0]     b_reps;

  opwfs_front #(
    .FRAME_BITS (FRAME_BITS),
    .UNIT_SCALE (UNIT_SCALE),
    .UNIT_W     (UNIT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (f_valid),
    .cmd_full   (q_full),
    .cmd_load   (f_load),
    .cmd_start  (f_start),
    .cmd_bits   (f_bits),
    .cmd_unit   (f_unit),
    .cmd_reps   (f_reps)
  );

  opwfs_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_data  ({f_load, f_start, f_bits, f_unit, f_reps}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  assign {b_load, b_start, b_bits, b_unit, b_reps} = q_data;

  opwfs_back #(
    .FRAME_BITS (FRAME_BITS),
    .UNIT_W     (UNIT_W),
    .TIME_W     (TIME_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd_take     (q_pop),
    .cmd_load     (b_load),
    .cmd_start    (b_start),
    .cmd_bits     (b_bits),
    .cmd_unit     (b_unit),
    .cmd_reps     (b_reps),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
